>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned STAT_W   = 2;

  localparam logic       ACT_ENQ = 1'b0;
  localparam logic       ACT_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [TAG_W-1:0]  tag;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   ins_en;
    logic   del_en;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

>>> rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted by descending signed priority in a
// chain of shift-insert cells; slot 0 always holds the next item to leave.
// ----------------------------------------------------------------------------
//  channel  dir  fields (tdata low to high)                   accepted when
//  s_axis   in   tuser: action / tdata: priority_req, tag      tvalid & tready
//  m_axis   out  tuser: status / tdata: out_priority, out_tag,  tvalid & tready
//                occupancy
//
//  one item per cycle while m_axis takes each result: every cell compares and shifts in the same cycle
//  the result is registered and shows on m_axis in the cycle after the item is taken
//  s_axis_tready is low only while a result waits and m_axis_tready is low
//  reset empties the queue and drops any pending result
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // priority_req[15:0], tag[31:16]
  input  logic [0:0]  s_axis_tuser,   // action[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_priority[15:0], out_tag[31:16],
                                      // occupancy[36:32], zero[39:37]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic                          s_accept;
  logic                          is_deq;
  logic                          full;
  logic                          empty;
  logic [spq_pkg::CNT_W-1:0]     count_q;
  logic [spq_pkg::CNT_W-1:0]     count_d;
  logic                          out_valid_q;
  logic                          out_valid_d;
  logic [spq_pkg::STAT_W-1:0]    status_q;
  logic [spq_pkg::STAT_W-1:0]    status_d;
  spq_pkg::entry_t               res_q;
  spq_pkg::entry_t               res_d;
  logic [spq_pkg::OCC_W-1:0]     occ_q;
  spq_pkg::cell_ctrl_t           ctrl;
  spq_pkg::entry_t               cell_entry [N];
  logic                          cell_greater [N];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign is_deq        = (s_axis_tuser[0] == spq_pkg::ACT_DEQ);
  assign full          = (count_q == spq_pkg::CNT_W'(N));
  assign empty         = (count_q == '0);

  always_comb begin
    ctrl.ins_en         = s_accept && !is_deq && !full;
    ctrl.del_en         = s_accept && is_deq && !empty;
    ctrl.new_entry.prio = s_axis_tdata[15:0];
    ctrl.new_entry.tag  = s_axis_tdata[31:16];
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_greater;

    if (i == 0) begin : g_head
      assign left_entry   = ctrl.new_entry;
      assign left_greater = 1'b1;
    end else begin : g_body
      assign left_entry   = cell_entry[i-1];
      assign left_greater = cell_greater[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occ_i          (count_q > spq_pkg::CNT_W'(i)),
      .left_greater_i (left_greater),
      .left_i         (left_entry),
      .right_i        (right_entry),
      .greater_o      (cell_greater[i]),
      .entry_o        (cell_entry[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = spq_pkg::ST_DONE;
    res_d    = '0;
    if (!is_deq) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        res_d   = cell_entry[0];
        count_d = count_q - 1'b1;
      end
    end
  end

  assign out_valid_d = s_accept || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, occ_q, res_q.tag, res_q.prio};

  // count stays within the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= spq_pkg::CNT_W'(N))
    else $error("count beyond capacity");

  // reported occupancy follows the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (occ_q == spq_pkg::OCC_W'(count_q)))
    else $error("occupancy out of step with count");

  // a successful removal drops exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.del_en |=> (count_q == $past(count_q) - 1'b1))
    else $error("removal did not shrink queue");

  // head never has lower priority than its neighbor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > spq_pkg::CNT_W'(1)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
    else $error("chain out of order");

endmodule

>>> rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps, takes the new item, takes its left
// neighbor on insert, or takes its right neighbor on removal.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic               occ_i,
  input  logic               left_greater_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    right_i,
  output logic               greater_o,
  output spq_pkg::entry_t    entry_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  assign greater_o = occ_i && (entry_q.prio > ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && !greater_o) begin
      entry_d = left_greater_i ? ctrl_i.new_entry : left_i;
    end else if (ctrl_i.del_en) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue: enqueue and dequeue items
// go in on s_axis, a shadow copy of the sorted entry store predicts status,
// removed entry and occupancy, and every m_axis item is checked against it.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP         = spq_pkg::CAPACITY;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] prio;
    logic [15:0]        tag;
    logic [4:0]         occupancy;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // priority_req[15:0], tag[31:16]
  logic [0:0]  s_axis_tuser;   // action[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_priority[15:0], out_tag[31:16], occupancy[36:32]
  logic [1:0]  m_axis_tuser;   // status[1:0]

  spq_pkg::entry_t held [CAP];
  int              held_count;
  outcome_t        op_outcomes [$];
  int              mismatches;
  int              cycle_count;
  bit              no_idle;

  sorted_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sorted_priority_queue: FAILED **");
      $finish;
    end
  end

  function automatic outcome_t apply_queue_op(logic act, logic signed [15:0] p,
                                              logic [15:0] t);
    outcome_t r;
    int pos;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    if (act == spq_pkg::ACT_ENQ) begin
      if (held_count >= CAP) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held[pos].prio > p) pos++;
        for (int i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].prio = p;
        held[pos].tag  = t;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.prio = held[0].prio;
        r.tag  = held[0].tag;
        for (int i = 1; i < held_count; i++) held[i-1] = held[i];
        held_count--;
      end
    end
    r.occupancy = held_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", field, got, want, cycle_count);
    mismatches++;
  endtask

  task automatic send_op(logic act, logic [15:0] p, logic [15:0] t);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {t, p};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    op_outcomes.push_back(apply_queue_op(act, p, t));
  endtask

  task automatic send_random_op(int enq_pct);
    send_op(($urandom_range(1, 100) <= enq_pct) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ,
            16'($urandom), 16'($urandom));
  endtask

  // receiver stalls in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (!no_idle && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (op_outcomes.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata, '0);
      end else begin
        w = op_outcomes.pop_front();
        if (m_axis_tuser !== w.status) report_mismatch("status", m_axis_tuser, w.status);
        if (m_axis_tdata[15:0] !== w.prio)
          report_mismatch("out_priority", m_axis_tdata[15:0], w.prio);
        if (m_axis_tdata[31:16] !== w.tag)
          report_mismatch("out_tag", m_axis_tdata[31:16], w.tag);
        if (m_axis_tdata[36:32] !== w.occupancy)
          report_mismatch("occupancy", m_axis_tdata[36:32], w.occupancy);
        if (m_axis_tdata[39:37] !== 3'b000)
          report_mismatch("pad", m_axis_tdata[39:37], '0);
      end
    end
  end

  // extremes, equal priorities, empty dequeue
  task automatic test_directed();
    send_op(spq_pkg::ACT_DEQ, 16'h0000, 16'h0000);
    send_op(spq_pkg::ACT_ENQ, 16'h7fff, 16'hffff);
    send_op(spq_pkg::ACT_ENQ, 16'h8000, 16'h0000);
    send_op(spq_pkg::ACT_ENQ, 16'h0000, 16'h1234);
    send_op(spq_pkg::ACT_ENQ, 16'hffff, 16'h8001);
    send_op(spq_pkg::ACT_ENQ, 16'h0000, 16'habcd);
    send_op(spq_pkg::ACT_ENQ, 16'h7fff, 16'h0001);
    repeat (3) begin
      send_op(spq_pkg::ACT_DEQ, 16'hffff, 16'hffff);
      send_op(spq_pkg::ACT_DEQ, 16'h0000, 16'h0000);
    end
    send_op(spq_pkg::ACT_DEQ, 16'hffff, 16'hffff);
  endtask

  // fill to capacity, push past full, drain to empty and beyond
  task automatic test_fill_drain(int rounds);
    repeat (rounds) begin
      while (held_count < CAP) send_random_op(100);
      repeat (2) send_random_op(100);
      while (held_count > 0) send_random_op(0);
      send_random_op(0);
    end
  endtask

  task automatic test_random_mix(int n);
    int enq_pct;
    enq_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 20;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      send_random_op(enq_pct);
    end
  endtask

  // few distinct priorities so ties are frequent
  task automatic test_close_priorities(int n);
    logic [15:0] p;
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: p = 16'hffff;
        1: p = 16'h0000;
        2: p = 16'h0001;
        3: p = 16'h7fff;
        default: p = 16'h8000;
      endcase
      send_op(($urandom_range(1, 100) <= 60) ? spq_pkg::ACT_ENQ : spq_pkg::ACT_DEQ,
              p, 16'($urandom));
    end
  endtask

  task automatic test_full_rate(int n);
    no_idle = 1'b1;
    repeat (n) send_random_op(55);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    held_count    = 0;
    mismatches    = 0;
    cycle_count   = 0;
    no_idle       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_fill_drain(3);
    test_random_mix(200);
    test_close_priorities(120);
    test_full_rate(120);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (op_outcomes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** sorted_priority_queue: PASSED **");
    end else begin
      $display("** sorted_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

>>> sorted_priority_queue.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
sim/tb.sv
